### design/sil_pkg.sv
// ============================================================================
// sil_pkg
// Shared types and constants for the sorted insertion list.
// ============================================================================
`default_nettype none

package sil_pkg;

  // Number of cells in the chain.
  localparam int unsigned CAPACITY = 16;
  // Width of the internal count, wide enough to hold CAPACITY itself.
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 5;

  // Operation codes carried in the kind field.
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DUMP   = 1'b1
  } kind_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_e;

  // Input word.
  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] value;
  } in_t;

  // Output word.
  typedef struct packed {
    logic signed [DATA_W-1:0] item;
    logic [COUNT_W-1:0]       count;
    logic                     full_drop;
    logic                     empty_res;
    logic                     last;
  } out_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                     insert;
    logic                     rotate;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage : sil_pkg

`default_nettype wire

### design/sil_cell.sv
// ============================================================================
// sil_cell
// One storage cell of the sorted chain, holding a single value.
// ============================================================================
`default_nettype none

module sil_cell import sil_pkg::*; (
  input  wire logic                     clk_i,
  input  wire cell_ctrl_t               ctrl_i,
  input  wire logic                     valid_i,
  input  wire logic                     tail_i,
  input  wire logic                     left_ge_i,
  input  wire logic signed [DATA_W-1:0] left_entry_i,
  input  wire logic signed [DATA_W-1:0] right_entry_i,
  input  wire logic signed [DATA_W-1:0] head_entry_i,
  output logic                          ge_o,
  output logic signed [DATA_W-1:0]      entry_o
);

  logic signed [DATA_W-1:0] entry_q;
  logic signed [DATA_W-1:0] entry_d;

  // An empty cell, or one whose value is not smaller, sits at or after the
  // insertion point.
  assign ge_o    = !valid_i || !(entry_q < ctrl_i.value);
  assign entry_o = entry_q;

  // On insert the cells after the insertion point take their left
  // neighbor's value and the first one takes the new value. On rotate the
  // valid prefix shifts toward the head and the head wraps to the tail.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (left_ge_i) begin
        entry_d = left_entry_i;
      end else if (ge_o) begin
        entry_d = ctrl_i.value;
      end
    end else if (ctrl_i.rotate && valid_i) begin
      entry_d = tail_i ? head_entry_i : right_entry_i;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule : sil_cell

`default_nettype wire

### design/sorted_insertion_list.sv
// ============================================================================
// sorted_insertion_list
// Keeps up to CAPACITY signed values in ascending order in a chain of cells.
// ============================================================================
// Usage:
// Input words arrive on in_valid_i/in_ready_o with in_i; results leave on
// out_valid_o/out_ready_i with out_o, through a single output register.
// On an insert word every cell compares its value with the
// new one in parallel and the chain shifts right by one from the insertion
// point, so inserts are accepted back to back while the output is drained.
// One result word with the new count appears the cycle after acceptance.
// A full list drops the insert and flags full_drop.
// A dump word streams the stored values one per cycle from the head cell
// while the receiver keeps up, and the chain rotates with each value;
// after count values it is back in its original order. The first value
// passes through the dump state and then the output register, and no input
// is accepted until the last value has left the dump state.
// An empty dump returns one word with empty_res set.
// When the receiver stalls, the output word holds and the block waits.
// Reset clears the count and the output valid; cell contents are not reset
// and only the first count cells are ever read.
// ============================================================================
`default_nettype none

module sorted_insertion_list import sil_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;
  cell_ctrl_t       ctrl;
  logic             out_free;
  logic             in_acc;

  logic signed [DATA_W-1:0] entry [CAPACITY];
  logic                     ge    [CAPACITY];

  // Chain of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     valid;
    logic                     tail;
    logic                     left_ge;
    logic signed [DATA_W-1:0] left_entry;
    logic signed [DATA_W-1:0] right_entry;

    assign valid = CNT_W'(i) < count_q;
    assign tail  = CNT_W'(i) == count_q - CNT_W'(1);

    if (i == 0) begin : g_head
      assign left_ge    = 1'b0;
      assign left_entry = entry[0];
    end else begin : g_body
      assign left_ge    = ge[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_entry = entry[i];
    end else begin : g_mid
      assign right_entry = entry[i+1];
    end

    sil_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .valid_i       (valid),
      .tail_i        (tail),
      .left_ge_i     (left_ge),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .head_entry_i  (entry[0]),
      .ge_o          (ge[i]),
      .entry_o       (entry[i])
    );
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && out_free;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Next state, cell commands and the output word.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ctrl.insert = 1'b0;
    ctrl.rotate = 1'b0;
    ctrl.value  = in_i.value;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_d     = 1'b1;
          out_d           = '0;
          out_d.last      = 1'b1;
          if (in_i.kind == KIND_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              out_d.full_drop = 1'b1;
              out_d.count     = COUNT_W'(count_q);
            end else begin
              ctrl.insert = 1'b1;
              count_d     = count_q + CNT_W'(1);
              out_d.count = COUNT_W'(count_d);
            end
          end else if (count_q == '0) begin
            out_d.empty_res = 1'b1;
          end else begin
            out_valid_d = 1'b0;
            idx_d       = '0;
            state_d     = ST_DUMP;
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          ctrl.rotate     = 1'b1;
          out_valid_d     = 1'b1;
          out_d.item      = entry[0];
          out_d.count     = COUNT_W'(count_q);
          out_d.full_drop = 1'b0;
          out_d.empty_res = 1'b0;
          out_d.last      = idx_q == count_q - CNT_W'(1);
          idx_d           = idx_q + CNT_W'(1);
          if (out_d.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // The count never exceeds the number of cells.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count exceeds capacity");

  // A dump only runs over a non-empty list and never past its end.
  a_dump_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> idx_q < count_q)
    else $error("dump index past stored count");

  // Every accepted insert word produces an output word in the next cycle.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.kind == KIND_INSERT |=> out_valid_q && out_q.last)
    else $error("insert produced no result");

  // A dropped insert only happens on a full list.
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.full_drop |-> count_q == CNT_W'(CAPACITY))
    else $error("drop reported on a list that is not full");

endmodule : sorted_insertion_list

`default_nettype wire
